[sv/pipw_pkg.sv]
// ----------------------------------------------------------------------------
// pipw_pkg
// Shared constants and controller/datapath interface types for the
// winding number point-in-polygon block.
// ----------------------------------------------------------------------------
`default_nettype none

package pipw_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 5;
    localparam int WN_W         = 6;
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CROSS_W      = PROD_W + 1;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic              wr_en;
        logic              load_point;
        logic              clear_wn;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              first;
        logic              wrap;
        logic              publish;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic busy;
        logic out_full;
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/point_in_polygon_winding.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_winding
// Point containment by the winding number rule over up to sixteen stored
// vertices; loads write the store, tests return winding and inside flag.
// ----------------------------------------------------------------------------
// a load writes the store on transfer; a test walks its n vertices (n being
//   the saturated vertex count) and the closing edge, drains and publishes
// throughput: one edge per cycle from the single store read port, one test
//   in flight; the next item is taken once the result sits in the output reg
// reset: synchronous active low; clears control and the vertex count, the
//   vertex store is left unwritten
`default_nettype none

module point_in_polygon_winding (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [pipw_pkg::CNT_W-1:0]             i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_op,
    input  wire logic [pipw_pkg::ADDR_W-1:0]            i_vertex_index,
    input  wire logic signed [pipw_pkg::COORD_WIDTH-1:0] i_coord_x,
    input  wire logic signed [pipw_pkg::COORD_WIDTH-1:0] i_coord_y,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic                                        o_inside_res,
    output logic signed [pipw_pkg::WN_W-1:0]            o_winding
);
    import pipw_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    pipw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // store, edge pipeline and output register
    pipw_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_inside_res   (o_inside_res),
        .o_winding      (o_winding)
    );

endmodule

`default_nettype wire

[sv/pipw_dpath.sv]
// ----------------------------------------------------------------------------
// pipw_dpath
// Vertex store, edge pipeline (read, differences, products, sign/accumulate)
// and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pipw_dpath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire pipw_pkg::t_dp_cmd                    i_cmd,
    output pipw_pkg::t_dp_stat                        o_stat,
    input  wire logic [pipw_pkg::ADDR_W-1:0]          i_vertex_index,
    input  wire logic signed [pipw_pkg::COORD_WIDTH-1:0] i_coord_x,
    input  wire logic signed [pipw_pkg::COORD_WIDTH-1:0] i_coord_y,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic                                      o_inside_res,
    output logic signed [pipw_pkg::WN_W-1:0]          o_winding
);
    import pipw_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // vertex store, {y, x} per entry
    logic [2*COORD_WIDTH-1:0] mem [MAX_VERTICES];
    logic [2*COORD_WIDTH-1:0] r_rd_data;

    // query point
    t_coord r_px, r_py;

    // walk registers
    t_coord r_prev_x, r_prev_y, r_first_x, r_first_y;

    // stage flags
    logic r_s1_valid, r_s1_first, r_s1_wrap;
    logic r_s2_valid, r_s3_valid;

    // stage 2 / 3 payload
    logic signed [DIFF_W-1:0]  r_a, r_b, r_c, r_d;
    logic                      r_s2_up, r_s2_down;
    logic signed [PROD_W-1:0]  r_m1, r_m2;
    logic                      r_s3_up, r_s3_down;

    logic signed [WN_W-1:0] r_wn;
    logic                   r_out_valid;
    logic                   r_inside;
    logic signed [WN_W-1:0] r_winding;

    // stage 1 combinational
    t_coord                   rd_x, rd_y, p1_x, p1_y;
    logic signed [DIFF_W-1:0] n_a, n_b, n_c, n_d;
    logic                     n_up, n_down;
    logic signed [CROSS_W-1:0] cross_val;

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_vertex_index] <= {i_coord_y, i_coord_x};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.rd_addr];
        end
    end

    // edge endpoints and differences
    always_comb begin
        rd_x = t_coord'(r_rd_data[COORD_WIDTH-1:0]);
        rd_y = t_coord'(r_rd_data[2*COORD_WIDTH-1:COORD_WIDTH]);
        p1_x = r_s1_wrap ? r_first_x : rd_x;
        p1_y = r_s1_wrap ? r_first_y : rd_y;
        n_a  = DIFF_W'(p1_x) - DIFF_W'(r_prev_x);
        n_b  = DIFF_W'(r_py) - DIFF_W'(r_prev_y);
        n_c  = DIFF_W'(r_px) - DIFF_W'(r_prev_x);
        n_d  = DIFF_W'(p1_y) - DIFF_W'(r_prev_y);
        n_up   = (r_prev_y <= r_py) && (p1_y > r_py);
        n_down = (r_prev_y > r_py) && (p1_y <= r_py);
        cross_val = CROSS_W'(r_m1) - CROSS_W'(r_m2);
    end

    // payload registers of the edge pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_s1_valid && r_s1_first) begin
            r_first_x <= rd_x;
            r_first_y <= rd_y;
        end
        if (r_s1_valid && !r_s1_wrap) begin
            r_prev_x <= rd_x;
            r_prev_y <= rd_y;
        end
        r_a       <= n_a;
        r_b       <= n_b;
        r_c       <= n_c;
        r_d       <= n_d;
        r_s2_up   <= n_up;
        r_s2_down <= n_down;
        r_m1      <= r_a * r_b;
        r_m2      <= r_c * r_d;
        r_s3_up   <= r_s2_up;
        r_s3_down <= r_s2_down;
    end

    // stage valids, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_first  <= 1'b0;
            r_s1_wrap   <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_wn        <= '0;
            r_out_valid <= 1'b0;
            r_inside    <= 1'b0;
            r_winding   <= '0;
        end else begin
            r_s1_valid <= i_cmd.rd_en || i_cmd.wrap;
            r_s1_first <= i_cmd.first;
            r_s1_wrap  <= i_cmd.wrap;
            r_s2_valid <= r_s1_valid && !r_s1_first;
            r_s3_valid <= r_s2_valid;

            if (i_cmd.clear_wn) begin
                r_wn <= '0;
            end else if (r_s3_valid) begin
                if (r_s3_up && cross_val > 0) begin
                    r_wn <= r_wn + WN_W'(1);
                end else if (r_s3_down && cross_val < 0) begin
                    r_wn <= r_wn - WN_W'(1);
                end
            end

            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
                r_inside    <= (r_wn != '0);
                r_winding   <= r_wn;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.busy     = r_s1_valid || r_s2_valid || r_s3_valid;
    assign o_stat.out_full = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_inside_res    = r_inside;
    assign o_winding       = r_winding;

    // a result is only published once the edge pipeline has drained
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> !$past(o_stat.busy))
        else $error("result published while edge pipeline busy");

    // winding stays within the vertex bound
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wn <= WN_W'(MAX_VERTICES)) && (r_wn >= -WN_W'(MAX_VERTICES)))
        else $error("winding accumulator out of range");

    // the accumulator is not cleared while edges are still in flight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_wn |-> !r_s3_valid)
        else $error("winding cleared during a walk");

endmodule

`default_nettype wire

[sv/pipw_ctrl.sv]
// ----------------------------------------------------------------------------
// pipw_ctrl
// Controller: input handshake, vertex count register and the edge walk
// sequencer that drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pipw_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pipw_pkg::CNT_W-1:0]  i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_op,
    output pipw_pkg::t_dp_cmd                o_cmd,
    input  wire pipw_pkg::t_dp_stat          i_stat
);
    import pipw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_WRAP,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_idx;
    logic [CNT_W-1:0]    r_vertex_count;
    logic [CNT_W-1:0]    n_used;
    logic                in_xfer;
    logic                last_idx;

    // saturate the count to the store depth
    always_comb begin
        n_used   = (r_vertex_count > CNT_W'(MAX_VERTICES)) ?
                   CNT_W'(MAX_VERTICES) : r_vertex_count;
        in_xfer  = i_in_valid && o_in_ready;
        last_idx = (CNT_W'(r_idx) == (n_used - CNT_W'(1)));
    end

    assign o_in_ready = (r_state == S_IDLE);

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_en      = in_xfer && (i_op == OP_LOAD);
        o_cmd.load_point = in_xfer && (i_op == OP_TEST);
        o_cmd.clear_wn   = in_xfer && (i_op == OP_TEST);
        o_cmd.rd_en      = (r_state == S_WALK);
        o_cmd.rd_addr    = r_idx;
        o_cmd.first      = (r_state == S_WALK) && (r_idx == '0);
        o_cmd.wrap       = (r_state == S_WRAP);
        o_cmd.publish    = (r_state == S_DONE) && !i_stat.out_full;
    end

    // state, walk index and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_idx          <= '0;
            r_vertex_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (in_xfer && (i_op == OP_TEST)) begin
                        r_state <= (n_used == '0) ? S_DONE : S_WALK;
                    end
                end
                S_WALK: begin
                    if (last_idx) begin
                        r_state <= S_WRAP;
                    end else begin
                        r_idx <= r_idx + ADDR_W'(1);
                    end
                end
                S_WRAP: begin
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!i_stat.busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_stat.out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // reads stay inside the polygon in use
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (CNT_W'(r_idx) < n_used))
        else $error("vertex read beyond polygon");

    // the store is only written between tests
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> (r_state == S_IDLE))
        else $error("vertex write during a walk");

    // the closing edge always follows the last vertex read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && last_idx |=> (r_state == S_WRAP))
        else $error("closing edge not issued");

endmodule

`default_nettype wire
